/* rtl/core/assert_macros.svh */
// Assertion macros shared by the projected point-in-polygon RTL.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define PPP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define PPP_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PPP_ASSERT(label, prop, msg)
`define PPP_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* rtl/core/ppp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and helpers of the projected point-in-polygon block.
// No dependencies; used by ppp_if, the edge unit, the sequencer and the top level.
package ppp_pkg;

	localparam int COORD_W      = 32;
	localparam int VTX_W        = 3 * COORD_W;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;
	localparam int CMP_W        = PROD_W + 1;
	localparam int MAX_VERTICES = 64;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_TEST   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		AXIS_X    = 2'd0,
		AXIS_Y    = 2'd1,
		AXIS_Z    = 2'd2,
		AXIS_NONE = 2'd3
	} axis_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRIME,
		S_LOAD,
		S_EDGE,
		S_MUL2,
		S_DONE
	} seq_state_t;

	// Control from the sequencer to the edge unit.
	typedef struct packed {
		logic clear_par;
		logic load_prev;
		logic mul_first;
		logic mul_second;
	} edge_ctrl_t;

	// A point on the projection plane: horizontal and vertical coordinate.
	typedef struct packed {
		logic signed [COORD_W-1:0] h;
		logic signed [COORD_W-1:0] v;
	} proj_t;

	function automatic proj_t project(axis_t axis, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
		proj_t p;
		unique case (axis)
			AXIS_X:    begin p.h = y; p.v = z; end
			AXIS_Y:    begin p.h = z; p.v = x; end
			AXIS_Z:    begin p.h = x; p.v = y; end
			AXIS_NONE: begin p.h = '0; p.v = '0; end
			default:   begin p.h = '0; p.v = '0; end
		endcase
		return p;
	endfunction

endpackage

/* rtl/core/ppp_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the block.
// Depends on ppp_pkg for the coordinate width.
interface ppp_req_if;
	logic                              valid;
	logic                              ready;
	logic [1:0]                        kind;
	logic signed [ppp_pkg::COORD_W-1:0] coord_x;
	logic signed [ppp_pkg::COORD_W-1:0] coord_y;
	logic signed [ppp_pkg::COORD_W-1:0] coord_z;

	modport source (output valid, kind, coord_x, coord_y, coord_z, input ready);
	modport sink (input valid, kind, coord_x, coord_y, coord_z, output ready);
endinterface

interface ppp_res_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic truncated;

	modport source (output valid, inside_res, truncated, input ready);
	modport sink (input valid, inside_res, truncated, output ready);
endinterface

/* rtl/core/ppp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ppp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/ppp_edge_unit.sv */
`timescale 1ns / 1ps
// Edge unit: straddle check, shared 33x33 multiplier and exact crossing compare.
// Depends on ppp_pkg.
module ppp_edge_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ppp_pkg::edge_ctrl_t                ctrl,
	input  ppp_pkg::proj_t                     cur,
	input  logic signed [ppp_pkg::COORD_W-1:0] th,
	input  logic signed [ppp_pkg::COORD_W-1:0] tv,
	output logic                               straddle,
	output logic                               parity
);

	localparam int DW = ppp_pkg::DIFF_W;
	localparam int PW = ppp_pkg::PROD_W;
	localparam int CW = ppp_pkg::CMP_W;

	logic signed [ppp_pkg::COORD_W-1:0] hj_q, vj_q;
	logic signed [DW-1:0] den, a, b, d, b_q, d_q, op_a, op_b;
	logic signed [PW-1:0] prod, prod_q;
	logic signed [CW-1:0] diff;
	logic den_neg_q, par_q, s_neg, s_pos, left;

	// Edge (j,i): j is the previous vertex, i the one read now.
	assign den = DW'(vj_q) - DW'(cur.v);
	assign a   = DW'(th) - DW'(cur.h);
	assign b   = DW'(hj_q) - DW'(cur.h);
	assign d   = DW'(tv) - DW'(cur.v);

	assign straddle = (cur.v > tv) != (vj_q > tv);

	// The one multiplier forms (th-hi)*den first, then (hj-hi)*(tv-vi).
	assign op_a = ctrl.mul_second ? b_q : a;
	assign op_b = ctrl.mul_second ? d_q : den;
	assign prod = op_a * op_b;

	assign diff  = CW'(prod_q) - CW'(prod);
	assign s_neg = diff[CW-1];
	assign s_pos = !s_neg && (diff != '0);
	assign left  = den_neg_q ? s_pos : s_neg;

	always_ff @(posedge clk) begin
		if (ctrl.load_prev) begin
			hj_q <= cur.h;
			vj_q <= cur.v;
		end
		if (ctrl.mul_first) begin
			prod_q    <= prod;
			b_q       <= b;
			d_q       <= d;
			den_neg_q <= den[DW-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q <= 1'b0;
		end else if (ctrl.clear_par) begin
			par_q <= 1'b0;
		end else if (ctrl.mul_second) begin
			par_q <= par_q ^ left;
		end
	end

	assign parity = par_q;

endmodule

/* rtl/core/ppp_seq.sv */
`timescale 1ns / 1ps
// Sequencer: walks the stored vertices for one test and steers the edge unit.
// Depends on ppp_pkg.
module ppp_seq #(
	parameter int MAX = ppp_pkg::MAX_VERTICES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       trivial,
	input  logic [$clog2(MAX+1)-1:0]   n,
	input  logic                       straddle,
	input  logic                       out_free,
	output logic [$clog2(MAX)-1:0]     rd_addr,
	output ppp_pkg::edge_ctrl_t        ctrl,
	output logic                       busy,
	output logic                       done
);

	localparam int AW = $clog2(MAX);
	localparam int CW = $clog2(MAX+1);

	ppp_pkg::seq_state_t state_q, state_d;
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] nm1;
	logic          last;

	assign nm1  = n - CW'(1);
	assign last = (CW'(idx_q) == nm1);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ppp_pkg::S_IDLE:  if (start) state_d = trivial ? ppp_pkg::S_DONE : ppp_pkg::S_PRIME;
			ppp_pkg::S_PRIME: state_d = ppp_pkg::S_LOAD;
			ppp_pkg::S_LOAD:  state_d = ppp_pkg::S_EDGE;
			ppp_pkg::S_EDGE: begin
				if (straddle) begin
					state_d = ppp_pkg::S_MUL2;
				end else if (last) begin
					state_d = ppp_pkg::S_DONE;
				end
			end
			ppp_pkg::S_MUL2:  state_d = last ? ppp_pkg::S_DONE : ppp_pkg::S_EDGE;
			ppp_pkg::S_DONE:  if (out_free) state_d = ppp_pkg::S_IDLE;
			default:          state_d = ppp_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctrl    = '0;
		rd_addr = idx_q;
		idx_d   = idx_q;
		done    = 1'b0;
		unique case (state_q)
			ppp_pkg::S_IDLE:  ctrl.clear_par = start;
			ppp_pkg::S_PRIME: rd_addr = nm1[AW-1:0];
			ppp_pkg::S_LOAD: begin
				ctrl.load_prev = 1'b1;
				rd_addr        = '0;
				idx_d          = '0;
			end
			ppp_pkg::S_EDGE: begin
				if (straddle) begin
					ctrl.mul_first = 1'b1;
				end else begin
					ctrl.load_prev = 1'b1;
					if (!last) begin
						idx_d   = idx_q + AW'(1);
						rd_addr = idx_q + AW'(1);
					end
				end
			end
			ppp_pkg::S_MUL2: begin
				ctrl.mul_second = 1'b1;
				ctrl.load_prev  = 1'b1;
				if (!last) begin
					idx_d   = idx_q + AW'(1);
					rd_addr = idx_q + AW'(1);
				end
			end
			ppp_pkg::S_DONE:  done = out_free;
			default:          ctrl = '0;
		endcase
	end

	assign busy = (state_q != ppp_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppp_pkg::S_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

/* rtl/core/point_in_polygon_projected.sv */
`timescale 1ns / 1ps
// Top level of the projected point-in-polygon tester.
// Depends on ppp_pkg, ppp_if, ppp_ram, ppp_edge_unit, ppp_seq and assert_macros.svh.
//
// This block keeps a polygon of up to MAX vertices, each a 3D point in signed
// Q16.16, and answers test requests with an even-odd ray-casting inside check
// on the plane picked by projection_axis (x gives (y,z), y gives (z,x), z gives
// (x,y); the invalid code always answers outside). A clear request empties the
// store and the truncation flag, an append request stores one vertex, and a
// vertex that finds the store full is dropped and sets the sticky truncated
// flag, which is reported with every test answer. Only a test request gives a
// result; a request with the unused kind code is taken and ignored. Clear and
// append requests never make the block busy. A test holds the block from its
// acceptance until the next request can be taken: the sequencer primes a read
// of the last stored vertex, loads it as the previous vertex and then walks
// the store one vertex per cycle, since the vertex store has one read port;
// each edge that straddles the test point's horizontal line takes an extra
// step because a single 33x33 multiplier forms both cross products of the
// exact crossing compare. A test on an empty polygon or with the invalid axis
// skips the walk. The result sits in an output register, so the block can
// take further requests while an answer waits to be collected, but a later
// test cannot finish until that register has been emptied. The vertex store
// is never cleared; only entries below the vertex count are ever read.
module point_in_polygon_projected #(
	parameter int MAX = ppp_pkg::MAX_VERTICES
) (
	input  logic        clk,
	input  logic        arst_n,
	ppp_req_if.sink     req,
	ppp_res_if.source   res,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	`include "assert_macros.svh"

	localparam int AW = $clog2(MAX);
	localparam int CW = $clog2(MAX+1);

	ppp_pkg::axis_t   axis_q;
	logic [CW-1:0]    vcount_q;
	logic             ovf_q;
	logic             accept;
	logic             busy;
	logic             done;
	logic             out_free;
	logic             start_test;
	logic             trivial;
	logic             straddle;
	logic             parity;
	logic             wr_en;
	logic [AW-1:0]    rd_addr;
	logic [ppp_pkg::VTX_W-1:0] wr_data, rd_data;
	ppp_pkg::edge_ctrl_t ctrl;
	ppp_pkg::proj_t   pt_proj, cur_proj;
	logic signed [ppp_pkg::COORD_W-1:0] th_q, tv_q;
	logic             res_valid_q, inside_q, trunc_q;

	// The block takes a new request whenever no test is running.
	assign req.ready = !busy;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= ppp_pkg::AXIS_Z;
		end else if (cfg_we) begin
			axis_q <= ppp_pkg::axis_t'(cfg_wdata);
		end
	end

	// Request decode. An append only writes while there is room.
	always_comb begin
		wr_en      = 1'b0;
		start_test = 1'b0;
		if (accept) begin
			unique case (ppp_pkg::kind_t'(req.kind))
				ppp_pkg::KIND_CLEAR:  wr_en = 1'b0;
				ppp_pkg::KIND_APPEND: wr_en = (vcount_q < CW'(MAX));
				ppp_pkg::KIND_TEST:   start_test = 1'b1;
				default:              wr_en = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= '0;
			ovf_q    <= 1'b0;
		end else if (accept) begin
			unique case (ppp_pkg::kind_t'(req.kind))
				ppp_pkg::KIND_CLEAR: begin
					vcount_q <= '0;
					ovf_q    <= 1'b0;
				end
				ppp_pkg::KIND_APPEND: begin
					if (wr_en) begin
						vcount_q <= vcount_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
				ppp_pkg::KIND_TEST:   vcount_q <= vcount_q;
				default:              vcount_q <= vcount_q;
			endcase
		end
	end

	// The test point is projected once, when the request is taken.
	assign pt_proj = ppp_pkg::project(axis_q, req.coord_x, req.coord_y, req.coord_z);

	always_ff @(posedge clk) begin
		if (start_test) begin
			th_q <= pt_proj.h;
			tv_q <= pt_proj.v;
		end
	end

	// An invalid axis or an empty polygon answers outside without a walk.
	assign trivial = (axis_q == ppp_pkg::AXIS_NONE) || (vcount_q == '0);

	assign wr_data = {req.coord_z, req.coord_y, req.coord_x};

	ppp_ram #(
		.WIDTH (ppp_pkg::VTX_W),
		.DEPTH (MAX)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (vcount_q[AW-1:0]),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Stored vertices are projected on the way out of the store.
	assign cur_proj = ppp_pkg::project(axis_q,
		rd_data[ppp_pkg::COORD_W-1:0],
		rd_data[2*ppp_pkg::COORD_W-1:ppp_pkg::COORD_W],
		rd_data[3*ppp_pkg::COORD_W-1:2*ppp_pkg::COORD_W]);

	ppp_seq #(
		.MAX (MAX)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_test),
		.trivial  (trivial),
		.n        (vcount_q),
		.straddle (straddle),
		.out_free (out_free),
		.rd_addr  (rd_addr),
		.ctrl     (ctrl),
		.busy     (busy),
		.done     (done)
	);

	ppp_edge_unit u_edge (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.cur      (cur_proj),
		.th       (th_q),
		.tv       (tv_q),
		.straddle (straddle),
		.parity   (parity)
	);

	// Result register. It can be refilled in the cycle it is emptied.
	assign out_free = !res_valid_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (done) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			inside_q <= parity;
			trunc_q  <= ovf_q;
		end
	end

	assign res.valid      = res_valid_q;
	assign res.inside_res = inside_q;
	assign res.truncated  = trunc_q;

	`PPP_ASSERT_NEVER(a_count_in_range, vcount_q > CW'(MAX), "vertex count beyond capacity")
	`PPP_ASSERT(a_trunc_only_full, ovf_q |-> (vcount_q == CW'(MAX)), "truncated with room left")
	`PPP_ASSERT(a_test_blocks, start_test |=> !req.ready, "request taken during a test")

endmodule

/* bench/polygon_shadow_pkg.sv */
`timescale 1ns / 1ps
// Shadow copy of the polygon store, the even-odd answer predictor and the queue
// of answers still awaited from the block. Depends on ppp_pkg for codes and widths.
package polygon_shadow_pkg;
	import ppp_pkg::*;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic inside_res;
		logic truncated;
	} answer_t;

	class polygon_shadow;
		coord_t      vert_x[MAX_VERTICES];
		coord_t      vert_y[MAX_VERTICES];
		coord_t      vert_z[MAX_VERTICES];
		int unsigned vert_count;
		bit          dropped;
		axis_t       axis;
		answer_t     awaited_answers[$];
		int unsigned mismatches;

		function new();
			vert_count = 0;
			dropped = 0;
			axis = AXIS_Z;
			mismatches = 0;
		endfunction

		function void set_axis(axis_t a);
			axis = a;
		endfunction

		function int unsigned pending();
			return awaited_answers.size();
		endfunction

		function void report(string msg);
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t ns: mismatch: %s", $time, msg);
			end
		endfunction

		// Drops the extrude axis and returns the horizontal and vertical coordinate.
		function void to_plane(coord_t x, coord_t y, coord_t z, output coord_t h,
				output coord_t v);
			case (axis)
				AXIS_X: begin h = y; v = z; end
				AXIS_Y: begin h = z; v = x; end
				default: begin h = x; v = y; end
			endcase
		endfunction

		// Casts a ray towards +h and counts edge crossings strictly to the right of
		// the point. The crossing compare is done on exact 68-bit products.
		function bit even_odd_inside(coord_t x, coord_t y, coord_t z);
			coord_t                    th, tv, hi, vi, hj, vj;
			logic signed [2*DIFF_W+1:0] a, b, c, d, lhs, rhs;
			bit                        parity;
			bit                        left;
			int unsigned               j;
			parity = 0;
			if (axis == AXIS_NONE || vert_count == 0) begin
				return 0;
			end
			to_plane(x, y, z, th, tv);
			j = vert_count - 1;
			for (int unsigned i = 0; i < vert_count; i++) begin
				to_plane(vert_x[i], vert_y[i], vert_z[i], hi, vi);
				to_plane(vert_x[j], vert_y[j], vert_z[j], hj, vj);
				if ((vi > tv) != (vj > tv)) begin
					a = th - hi;
					b = vj - vi;
					c = hj - hi;
					d = tv - vi;
					lhs = a * b;
					rhs = c * d;
					left = (b > 0) ? (lhs < rhs) : (lhs > rhs);
					parity ^= left;
				end
				j = i;
			end
			return parity;
		endfunction

		function void note_request(logic [1:0] kind, coord_t x, coord_t y, coord_t z);
			answer_t ans;
			case (kind)
				KIND_CLEAR: begin
					vert_count = 0;
					dropped = 0;
				end
				KIND_APPEND: begin
					if (vert_count < MAX_VERTICES) begin
						vert_x[vert_count] = x;
						vert_y[vert_count] = y;
						vert_z[vert_count] = z;
						vert_count++;
					end else begin
						dropped = 1;
					end
				end
				KIND_TEST: begin
					ans.inside_res = even_odd_inside(x, y, z);
					ans.truncated = dropped;
					awaited_answers.insert(awaited_answers.size(), ans);
				end
				default: ;
			endcase
		endfunction

		function void check_answer(logic inside_res, logic truncated);
			answer_t want;
			if (awaited_answers.size() == 0) begin
				report($sformatf("answer with no test waiting: inside_res %b truncated %b",
					inside_res, truncated));
				return;
			end
			want = awaited_answers.pop_front();
			if (inside_res !== want.inside_res) begin
				report($sformatf("inside_res expected %b actual %b", want.inside_res,
					inside_res));
			end
			if (truncated !== want.truncated) begin
				report($sformatf("truncated expected %b actual %b", want.truncated,
					truncated));
			end
		endfunction
	endclass

endpackage

/* bench/tb_point_in_polygon_projected.sv */
`timescale 1ns / 1ps
// Self-checking bench for the projected point-in-polygon block: directed and random
// requests under several idling patterns. Depends on ppp_pkg, ppp_if and polygon_shadow_pkg.
module tb_point_in_polygon_projected;
	import ppp_pkg::*;
	import polygon_shadow_pkg::*;

	// The kind code that the block takes and throws away.
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam coord_t ONE   = 32'sh0001_0000;
	localparam coord_t MIN_C = 32'sh8000_0000;
	localparam coord_t MAX_C = 32'sh7fff_ffff;

	// The settle time after the last awaited answer is well beyond the longest test,
	// which walks every stored edge once, with an extra step on each straddling one.
	localparam int SETTLE_CYCLES = 200;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int ITEM_TARGET   = 800;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	ppp_req_if req();
	ppp_res_if res();

	point_in_polygon_projected DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	polygon_shadow shadow = new();

	// Percentages of cycles in which the sender holds back and the receiver stalls.
	int gap_pct;
	int stall_pct;

	// Counts clear, append and test requests; ignored ones do not count.
	int unsigned requests_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Both handshakes are sampled on the values that stood before the edge, so the
	// answer is checked before a test request accepted on the same edge is noted.
	// The receiver's ready is redrawn on every edge from the stall percentage.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res.valid && res.ready) begin
				shadow.check_answer(res.inside_res, res.truncated);
			end
			if (req.valid && req.ready) begin
				shadow.note_request(req.kind, req.coord_x, req.coord_y, req.coord_z);
			end
		end
		res.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Draws one coordinate. The coarse grid makes vertices and test points share
	// lines often, so ties on the vertical compare come up; the full-range draw
	// toggles every bit; the extreme draw stresses the exact crossing compare.
	function automatic coord_t rand_coord(int unsigned mode);
		case (mode)
			0: return coord_t'((int'($urandom_range(16)) - 8) * 65536);
			1: return coord_t'((int'($urandom_range(4000)) - 2000) * 97);
			2: return coord_t'($urandom());
			default: begin
				case ($urandom_range(5))
					0: return MIN_C;
					1: return MAX_C;
					2: return '0;
					3: return -1;
					4: return coord_t'((int'($urandom_range(4)) - 2) * 65536);
					default: return coord_t'($urandom());
				endcase
			end
		endcase
	endfunction

	// Presents one request and returns on the edge at which it is accepted. In this
	// task the valid line is only lowered inside a gap, so it never gets two
	// assignments in one time step.
	task automatic send_request(input logic [1:0] kind, input coord_t x, input coord_t y,
			input coord_t z);
		while ($urandom_range(99) < gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.kind    <= kind;
		req.coord_x <= x;
		req.coord_y <= y;
		req.coord_z <= z;
		@(posedge clk);
		while (!req.ready) begin
			@(posedge clk);
		end
		if (kind != KIND_UNUSED) begin
			requests_sent++;
		end
	endtask

	// Stops sending, waits for every awaited answer and then lets the block settle,
	// since clear and append requests leave nothing behind to wait for.
	task automatic drain_answers();
		int unsigned guard;
		guard = 0;
		req.valid <= 1'b0;
		while (shadow.pending() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// The axis register is only written while the block is idle.
	task automatic write_axis(input axis_t axis);
		cfg_we    <= 1'b1;
		cfg_wdata <= axis;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_axis(axis);
	endtask

	// One random polygon followed by a burst of test requests. Mostly small
	// polygons; now and then a full store with a few vertices dropped. Sometimes
	// the clear is left out so that vertices pile up on the previous polygon, and
	// now and then a stray request of any kind, the unused one among them, is
	// slipped in between the appends.
	task automatic run_polygon();
		int unsigned mode;
		int unsigned size;
		int unsigned tests;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15) begin
			size = $urandom_range(2);
		end else if (pick < 80) begin
			size = $urandom_range(8, 3);
		end else if (pick < 95) begin
			size = $urandom_range(24, 9);
		end else begin
			size = $urandom_range(MAX_VERTICES + 6, MAX_VERTICES);
		end
		mode = $urandom_range(3);
		if ($urandom_range(9) != 0) begin
			send_request(KIND_CLEAR, rand_coord(2), rand_coord(2), rand_coord(2));
		end
		for (int unsigned k = 0; k < size; k++) begin
			if ($urandom_range(29) == 0) begin
				send_request(2'($urandom_range(3)), rand_coord(2), rand_coord(2),
					rand_coord(2));
			end
			send_request(KIND_APPEND, rand_coord(mode), rand_coord(mode), rand_coord(mode));
		end
		tests = $urandom_range(8, 3);
		for (int unsigned k = 0; k < tests; k++) begin
			send_request(KIND_TEST, rand_coord(mode), rand_coord(mode), rand_coord(mode));
		end
	endtask

	// Hard limit on the run, far beyond the slowest correct run.
	initial begin
		#10_000_000;
		$display("tb_point_in_polygon_projected: FAIL");
		$finish;
	end

	initial begin
		int unsigned phase;
		axis_t       axis;
		clk         = 1'b0;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_wdata   = AXIS_Z;
		req.valid   = 1'b0;
		req.kind    = KIND_CLEAR;
		req.coord_x = '0;
		req.coord_y = '0;
		req.coord_z = '0;
		res.ready   = 1'b0;
		gap_pct     = 0;
		stall_pct   = 0;
		requests_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, on the reset axis (z, so the plane is x,y). A test on the
		// empty store, an ignored request, tests on one and on two vertices, a
		// small triangle with points inside, outside and level with its vertices,
		// then a square spanning the full coordinate range.
		send_request(KIND_TEST, ONE, ONE, '0);
		send_request(KIND_UNUSED, MAX_C, MIN_C, MAX_C);
		send_request(KIND_APPEND, '0, '0, 3 * ONE);
		send_request(KIND_TEST, ONE, '0, '0);
		send_request(KIND_APPEND, 4 * ONE, '0, -ONE);
		send_request(KIND_TEST, ONE, ONE, '0);
		send_request(KIND_APPEND, '0, 4 * ONE, '0);
		send_request(KIND_TEST, ONE, ONE, '0);
		send_request(KIND_TEST, 5 * ONE, 5 * ONE, '0);
		send_request(KIND_TEST, ONE, '0, '0);
		send_request(KIND_TEST, '0, 2 * ONE, '0);
		send_request(KIND_TEST, MIN_C, MIN_C, MIN_C);
		send_request(KIND_TEST, MAX_C, MAX_C, MAX_C);
		send_request(KIND_CLEAR, '0, '0, '0);
		send_request(KIND_APPEND, MIN_C, MIN_C, MAX_C);
		send_request(KIND_APPEND, MAX_C, MIN_C, MIN_C);
		send_request(KIND_APPEND, MAX_C, MAX_C, '0);
		send_request(KIND_APPEND, MIN_C, MAX_C, MIN_C);
		send_request(KIND_TEST, '0, '0, '0);
		send_request(KIND_TEST, MAX_C, '0, '0);
		send_request(KIND_TEST, MIN_C + 1, MAX_C - 1, '0);
		send_request(KIND_TEST, -1, -1, -1);
		send_request(KIND_CLEAR, MAX_C, MAX_C, MAX_C);
		send_request(KIND_TEST, '0, '0, '0);
		drain_answers();

		// Random phases. Each one writes the axis while the block is idle, picks an
		// idling pattern and runs a few polygons; the first four phases walk every
		// axis code, both ends included. The drain at the end of each phase is
		// where the sender waits for every awaited answer before going on.
		phase = 0;
		while (requests_sent < ITEM_TARGET) begin
			case (phase)
				0: axis = AXIS_X;
				1: axis = AXIS_NONE;
				2: axis = AXIS_Y;
				3: axis = AXIS_Z;
				default: axis = axis_t'($urandom_range(3));
			endcase
			write_axis(axis);
			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 54; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 54; end
				default: begin gap_pct = 19; stall_pct = 19; end
			endcase
			repeat (3) run_polygon();
			drain_answers();
			phase++;
		end

		if (shadow.pending() != 0) begin
			$display("%0d test answers never arrived", shadow.pending());
		end
		if (shadow.mismatches == 0 && shadow.pending() == 0) begin
			$display("tb_point_in_polygon_projected: PASS");
		end else begin
			$display("tb_point_in_polygon_projected: FAIL");
		end
		$finish;
	end

endmodule
